@@ hdl/npsp_pkg.sv @@
package npsp_pkg;

	// Sentence bound; characters at or past it are dropped
	localparam int MAX_SENTENCE = 128;
	localparam int POS_W = $clog2(MAX_SENTENCE + 1);

	// Field widths
	localparam int BYTE_W    = 8;
	localparam int LAT_W     = 30;
	localparam int LON_W     = 35;
	localparam int LON_MAG_W = LON_W - 1;
	localparam int LAT_DEG_W = 7;
	localparam int LON_DEG_W = 10;
	localparam int MIN_W     = 20;

	// Characters of interest
	localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
	localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_R      = 8'h52;
	localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
	localparam logic [BYTE_W-1:0] CH_POINT  = 8'h2E;
	localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;

	// Fixed point conversion: e7 = deg * 1e7 + floor(min_e4 * 50 / 3)
	// min_e4 * 50 / 3 = 16 * min_e4 + floor(2 * min_e4 / 3)
	localparam logic [23:0] E7           = 24'd10000000;
	localparam int          RECIP3_SHIFT = 23;
	localparam logic [21:0] RECIP3       = 22'd2796203;

	// Captured position, handed from the parser to the converter
	typedef struct packed {
		logic                 valid;
		logic [LAT_DEG_W-1:0] lat_deg;
		logic [MIN_W-1:0]     lat_min;
		logic [LON_DEG_W-1:0] lon_deg;
		logic [MIN_W-1:0]     lon_min;
	} capture_t;

endpackage

@@ hdl/npsp_if.sv @@
// Received character channel
interface npsp_rx_if import npsp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// Position result channel
interface npsp_fix_if import npsp_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [LAT_W-1:0]        latitude_e7;
	logic signed [LON_W-1:0] longitude_e7;
	logic                    position_valid;

	modport source (output valid, output latitude_e7, output longitude_e7,
		output position_valid, input ready);
	modport sink (input valid, input latitude_e7, input longitude_e7,
		input position_valid, output ready);
endinterface

@@ hdl/npsp_parser.sv @@
module npsp_parser import npsp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_fire,
	input  logic [BYTE_W-1:0] rx_byte,
	output capture_t          cap
);

	typedef enum logic [1:0] {WIN_NONE, WIN_LAT, WIN_LON} win_t;

	localparam logic [3:0] LAT_DEG_LEN = 4'd2;
	localparam logic [3:0] LON_DEG_LEN = 4'd3;
	localparam logic [3:0] MIN_LEN     = 4'd7;
	localparam logic [2:0] COMMA_MAX   = 3'd7;
	localparam logic [2:0] COMMA_LAT   = 3'd3;
	localparam logic [2:0] COMMA_LON   = 3'd5;
	localparam logic [POS_W-1:0] POS_TYPE = POS_W'(3);
	localparam logic [POS_W-1:0] POS_MAX  = POS_W'(MAX_SENTENCE);
	localparam logic [6:0]  INT_MIN_SAT = 7'd100;
	localparam logic [20:0] MIN_SAT     = 21'd999999;

	// Minutes in 1e-4 units from integer part and fraction digits
	function automatic logic [MIN_W-1:0] minutes_e4(input logic [6:0] im,
			input logic [13:0] fv, input logic [2:0] fc);
		logic [20:0] scaled;
		logic [20:0] sum;
		begin
			case (fc)
				3'd0:    scaled = 21'(fv) * 21'd10000;
				3'd1:    scaled = 21'(fv) * 21'd1000;
				3'd2:    scaled = 21'(fv) * 21'd100;
				3'd3:    scaled = 21'(fv) * 21'd10;
				default: scaled = 21'(fv);
			endcase
			sum = 21'(im) * 21'd10000 + scaled;
			minutes_e4 = (sum > MIN_SAT) ? MIN_W'(MIN_SAT) : MIN_W'(sum);
		end
	endfunction

	logic                 in_sentence_q, in_sentence_d;
	logic [POS_W-1:0]     char_pos_q, char_pos_d;
	logic [2:0]           comma_q, comma_d;
	logic                 is_rmc_q, is_rmc_d;
	logic [3:0]           phase_q, phase_d;
	logic                 stopped_q, stopped_d;
	logic [LAT_DEG_W-1:0] lat_deg_q, lat_deg_d;
	logic [MIN_W-1:0]     lat_min_q, lat_min_d;
	logic [LON_DEG_W-1:0] lon_deg_q, lon_deg_d;
	logic [MIN_W-1:0]     lon_min_q, lon_min_d;
	win_t                 win_q, win_d;
	logic                 point_q, point_d;
	logic [6:0]           int_min_q, int_min_d;
	logic [13:0]          frac_q, frac_d;
	logic [2:0]           frac_cnt_q, frac_cnt_d;

	logic        digit;
	logic [3:0]  dval;
	logic [3:0]  deg_len;
	logic [9:0]  int_ext;
	logic [2:0]  comma_inc;
	logic [MIN_W-1:0] min_now;

	assign digit = rx_byte inside {[CH_ZERO:CH_NINE]};
	assign dval  = digit ? 4'(rx_byte - CH_ZERO) : 4'd0;

	// Result request on carriage return inside an RMC sentence
	always_comb begin
		cap.valid   = byte_fire && (rx_byte == CH_CR) && in_sentence_q && is_rmc_q;
		cap.lat_deg = lat_deg_q;
		cap.lat_min = lat_min_q;
		cap.lon_deg = lon_deg_q;
		cap.lon_min = lon_min_q;
	end

	// Per-character state update
	always_comb begin
		in_sentence_d = in_sentence_q;
		char_pos_d    = char_pos_q;
		comma_d       = comma_q;
		is_rmc_d      = is_rmc_q;
		phase_d       = phase_q;
		stopped_d     = stopped_q;
		lat_deg_d     = lat_deg_q;
		lat_min_d     = lat_min_q;
		lon_deg_d     = lon_deg_q;
		lon_min_d     = lon_min_q;
		win_d         = win_q;
		point_d       = point_q;
		int_min_d     = int_min_q;
		frac_d        = frac_q;
		frac_cnt_d    = frac_cnt_q;
		deg_len       = (win_q == WIN_LAT) ? LAT_DEG_LEN : LON_DEG_LEN;
		int_ext       = '0;
		comma_inc     = comma_q + 3'd1;
		min_now       = '0;

		if (byte_fire) begin
			if (rx_byte == CH_DOLLAR) begin
				in_sentence_d = 1'b1;
				char_pos_d    = POS_W'(1);
				comma_d       = '0;
				is_rmc_d      = 1'b0;
				phase_d       = '0;
				stopped_d     = 1'b0;
				lat_deg_d     = '0;
				lat_min_d     = '0;
				lon_deg_d     = '0;
				lon_min_d     = '0;
				win_d         = WIN_NONE;
				point_d       = 1'b0;
				int_min_d     = '0;
				frac_d        = '0;
				frac_cnt_d    = '0;
			end else if (rx_byte == CH_CR) begin
				if (in_sentence_q) begin
					in_sentence_d = 1'b0;
					win_d         = WIN_NONE;
				end
			end else if (in_sentence_q && (char_pos_q < POS_MAX)) begin
				char_pos_d = char_pos_q + POS_W'(1);
				if ((char_pos_q == POS_TYPE) && (rx_byte == CH_R)) begin
					is_rmc_d = 1'b1;
				end

				// Number window
				if (win_q != WIN_NONE) begin
					if (phase_q == deg_len) begin
						stopped_d  = 1'b0;
						point_d    = 1'b0;
						int_min_d  = '0;
						frac_d     = '0;
						frac_cnt_d = '0;
					end
					if (phase_q < deg_len) begin
						if (!stopped_d && digit) begin
							if (win_q == WIN_LAT) begin
								lat_deg_d = LAT_DEG_W'(lat_deg_q * 7'd10 + 7'(dval));
							end else begin
								lon_deg_d = LON_DEG_W'(lon_deg_q * 10'd10 + 10'(dval));
							end
						end else begin
							stopped_d = 1'b1;
						end
					end else if (!stopped_d) begin
						if (digit && !point_d) begin
							int_ext   = 10'(int_min_d) * 10'd10 + 10'(dval);
							int_min_d = (int_ext > 10'(INT_MIN_SAT)) ? INT_MIN_SAT
								: 7'(int_ext);
						end else if (digit) begin
							if (frac_cnt_d < 3'd4) begin
								frac_d     = 14'(frac_d * 14'd10 + 14'(dval));
								frac_cnt_d = frac_cnt_d + 3'd1;
							end
						end else if ((rx_byte == CH_POINT) && !point_d) begin
							point_d = 1'b1;
						end else begin
							stopped_d = 1'b1;
						end
						min_now = minutes_e4(int_min_d, frac_d, frac_cnt_d);
						if (win_q == WIN_LAT) begin
							lat_min_d = min_now;
						end else begin
							lon_min_d = min_now;
						end
					end
					phase_d = phase_q + 4'd1;
					if (phase_d >= deg_len + MIN_LEN) begin
						win_d = WIN_NONE;
					end
				end

				// Comma counting opens the windows
				if ((rx_byte == CH_COMMA) && (comma_q < COMMA_MAX)) begin
					comma_d = comma_inc;
					if (comma_inc == COMMA_LAT) begin
						win_d     = WIN_LAT;
						phase_d   = '0;
						stopped_d = 1'b0;
					end else if (comma_inc == COMMA_LON) begin
						win_d     = WIN_LON;
						phase_d   = '0;
						stopped_d = 1'b0;
					end
				end
			end
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_sentence_q <= 1'b0;
			char_pos_q    <= '0;
			comma_q       <= '0;
			is_rmc_q      <= 1'b0;
			phase_q       <= '0;
			stopped_q     <= 1'b0;
			win_q         <= WIN_NONE;
			point_q       <= 1'b0;
			frac_cnt_q    <= '0;
			lat_deg_q     <= '0;
			lat_min_q     <= '0;
			lon_deg_q     <= '0;
			lon_min_q     <= '0;
			int_min_q     <= '0;
			frac_q        <= '0;
		end else begin
			in_sentence_q <= in_sentence_d;
			char_pos_q    <= char_pos_d;
			comma_q       <= comma_d;
			is_rmc_q      <= is_rmc_d;
			phase_q       <= phase_d;
			stopped_q     <= stopped_d;
			win_q         <= win_d;
			point_q       <= point_d;
			frac_cnt_q    <= frac_cnt_d;
			lat_deg_q     <= lat_deg_d;
			lat_min_q     <= lat_min_d;
			lon_deg_q     <= lon_deg_d;
			lon_min_q     <= lon_min_d;
			int_min_q     <= int_min_d;
			frac_q        <= frac_d;
		end
	end

endmodule

@@ hdl/npsp_convert.sv @@
module npsp_convert import npsp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  capture_t         cap,
	output logic             cap_ready,
	npsp_fix_if.source       fix
);

	logic en1, en2, en3;
	logic v1_s1, v2_s2, v3_q;
	logic avail_q;

	capture_t             pos_s1;
	logic [LAT_W-1:0]     lat_deg_e7_s2;
	logic [23:0]          lat_min16_s2;
	logic [MIN_W-1:0]     lat_third_s2;
	logic [LON_MAG_W-1:0] lon_deg_e7_s2;
	logic [23:0]          lon_min16_s2;
	logic [MIN_W-1:0]     lon_third_s2;

	logic [LAT_W-1:0]     lat_sum;
	logic [LON_MAG_W-1:0] lon_sum;
	logic                 lat_big;
	logic [LAT_W-1:0]     lat_q;
	logic signed [LON_W-1:0] lon_q;
	logic                 pv_q;

	// Stage enables: a stage moves when its successor has room
	assign en3       = !v3_q || fix.ready;
	assign en2       = !v2_s2 || en3;
	assign en1       = !v1_s1 || en2;
	assign cap_ready = en1;

	// Final sums
	assign lat_sum = lat_deg_e7_s2 + LAT_W'(lat_min16_s2) + LAT_W'(lat_third_s2);
	assign lon_sum = lon_deg_e7_s2 + LON_MAG_W'(lon_min16_s2) + LON_MAG_W'(lon_third_s2);
	assign lat_big = lat_sum > LAT_W'(E7);

	// Valid bits and sticky flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1   <= 1'b0;
			v2_s2   <= 1'b0;
			v3_q    <= 1'b0;
			avail_q <= 1'b0;
		end else begin
			if (en1) v1_s1 <= cap.valid;
			if (en2) v2_s2 <= v1_s1;
			if (en3) v3_q <= v2_s2;
			if (en3 && v2_s2 && lat_big) avail_q <= 1'b1;
		end
	end

	// Stage 1: captured fields
	always_ff @(posedge clk) begin
		if (en1 && cap.valid) pos_s1 <= cap;
	end

	// Stage 2: degree products and minute thirds
	always_ff @(posedge clk) begin
		if (en2 && v1_s1) begin
			lat_deg_e7_s2 <= LAT_W'(pos_s1.lat_deg) * LAT_W'(E7);
			lon_deg_e7_s2 <= LON_MAG_W'(pos_s1.lon_deg) * LON_MAG_W'(E7);
			lat_min16_s2  <= {pos_s1.lat_min, 4'b0000};
			lon_min16_s2  <= {pos_s1.lon_min, 4'b0000};
			lat_third_s2  <= MIN_W'((43'({pos_s1.lat_min, 1'b0}) * 43'(RECIP3))
				>> RECIP3_SHIFT);
			lon_third_s2  <= MIN_W'((43'({pos_s1.lon_min, 1'b0}) * 43'(RECIP3))
				>> RECIP3_SHIFT);
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (en3 && v2_s2) begin
			lat_q <= lat_sum;
			lon_q <= -$signed({1'b0, lon_sum});
			pv_q  <= avail_q || lat_big;
		end
	end

	assign fix.valid          = v3_q;
	assign fix.latitude_e7    = lat_q;
	assign fix.longitude_e7   = lon_q;
	assign fix.position_valid = pv_q;

endmodule

@@ hdl/nmea_position_sentence_parser.sv @@
// Channel  Dir  Payload                                      Handshake
// rx       in   rx_byte[7:0]                                 valid / ready
// fix      out  latitude_e7[29:0], longitude_e7[34:0] (s),   valid / ready
//               position_valid
//
// One character is taken every cycle while rx.ready is high; the parser state
// updates in that cycle. A carriage return closing an RMC sentence is captured
// at the edge that accepts it; the multiply stage and the output register
// follow, and the position shows on fix from the output register.
// rx.ready drops only when the capture, multiply and output stages are all full
// and fix is stalled. arst_n clears all sentence state and the sticky valid flag.
module nmea_position_sentence_parser import npsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	npsp_rx_if.sink    rx,
	npsp_fix_if.source fix
);

	capture_t cap;
	logic     cap_ready;
	logic     byte_fire;

	assign rx.ready  = cap_ready;
	assign byte_fire = rx.valid && cap_ready;

	npsp_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_fire(byte_fire),
		.rx_byte  (rx.rx_byte),
		.cap      (cap)
	);

	npsp_convert u_convert (
		.clk      (clk),
		.arst_n   (arst_n),
		.cap      (cap),
		.cap_ready(cap_ready),
		.fix      (fix)
	);

	// Longitude is never east
	a_lon_west: assert property (@(posedge clk) disable iff (!arst_n)
		(fix.valid && !fix.longitude_e7[LON_W-1]) |-> (fix.longitude_e7 == '0))
		else $error("positive longitude");

	// A latitude over one degree carries the valid flag
	a_lat_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(fix.valid && (fix.latitude_e7 > LAT_W'(E7))) |-> fix.position_valid)
		else $error("valid flag missing");

	// Once shown, the valid flag stays on the following results
	a_flag_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(fix.valid && fix.ready && fix.position_valid) |=>
		(!fix.valid || fix.position_valid))
		else $error("valid flag dropped");

endmodule

@@ dv/npsp_fix_checker.sv @@
`timescale 1ns / 100ps

// Watches the character and position channels, runs a parser of its own on every
// accepted character and compares each position request with the oldest prediction.
module npsp_fix_checker import npsp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	npsp_rx_if   rx,
	npsp_fix_if  fix,
	output int   fail_count,
	output int   fixes_due,
	output int   fixes_predicted
);

	typedef enum logic [1:0] {WIN_NONE, WIN_LAT, WIN_LON} window_e;

	typedef struct packed {
		logic [LAT_W-1:0] lat;
		logic [LON_W-1:0] lon;
		logic             valid;
	} fix_t;

	// Parser state
	logic                 in_sent;
	logic [POS_W-1:0]     char_pos;
	logic [2:0]           commas;
	logic                 rmc;
	window_e              win;
	logic [3:0]           phase;
	logic                 stopped;
	logic                 point_seen;
	logic [6:0]           int_min;
	logic [13:0]          frac_val;
	logic [2:0]           frac_cnt;
	logic [LAT_DEG_W-1:0] lat_deg;
	logic [MIN_W-1:0]     lat_min;
	logic [LON_DEG_W-1:0] lon_deg;
	logic [MIN_W-1:0]     lon_min;
	logic                 sticky_valid;

	fix_t expected_fixes[$];
	fix_t want;

	task automatic clear_sentence();
		in_sent = 1'b0;
		char_pos = '0;
		commas = '0;
		rmc = 1'b0;
		win = WIN_NONE;
		phase = '0;
		stopped = 1'b0;
		point_seen = 1'b0;
		int_min = '0;
		frac_val = '0;
		frac_cnt = '0;
		lat_deg = '0;
		lat_min = '0;
		lon_deg = '0;
		lon_min = '0;
	endtask

	task automatic open_window(input window_e w);
		win = w;
		phase = '0;
		stopped = 1'b0;
	endtask

	// Minutes in 1e-4 units, missing fraction digits count as zeros
	function automatic logic [MIN_W-1:0] minutes_e4();
		int m;
		int scale;
		scale = 1;
		for (int k = int'(frac_cnt); k < 4; k++)
			scale = scale * 10;
		m = int'(int_min) * 10000 + int'(frac_val) * scale;
		if (m > 999999)
			m = 999999;
		return m[MIN_W-1:0];
	endfunction

	function automatic longint to_e7(input longint deg, input longint min_e4);
		return deg * 10000000 + (min_e4 * 50) / 3;
	endfunction

	// One character inside an open degree/minutes window
	task automatic feed_window(input logic [BYTE_W-1:0] c);
		int   deg_len;
		int   off;
		int   d;
		int   tmp;
		logic digit;
		deg_len = (win == WIN_LAT) ? 2 : 3;
		off = int'(phase);
		digit = (c >= CH_ZERO) && (c <= CH_NINE);
		d = digit ? int'(c - CH_ZERO) : 0;
		// minutes part restarts at its fixed offset
		if (off == deg_len) begin
			stopped = 1'b0;
			point_seen = 1'b0;
			int_min = '0;
			frac_val = '0;
			frac_cnt = '0;
		end
		if (off < deg_len) begin
			if (!stopped && digit) begin
				if (win == WIN_LAT)
					lat_deg = LAT_DEG_W'(int'(lat_deg) * 10 + d);
				else
					lon_deg = LON_DEG_W'(int'(lon_deg) * 10 + d);
			end else begin
				stopped = 1'b1;
			end
		end else if (!stopped) begin
			if (digit && !point_seen) begin
				tmp = int'(int_min) * 10 + d;
				int_min = (tmp > 100) ? 7'd100 : tmp[6:0];
			end else if (digit) begin
				// digits past the fourth fraction place are dropped
				if (frac_cnt < 4) begin
					frac_val = 14'(int'(frac_val) * 10 + d);
					frac_cnt = frac_cnt + 1'b1;
				end
			end else if (c == CH_POINT && !point_seen) begin
				point_seen = 1'b1;
			end else begin
				stopped = 1'b1;
			end
			if (win == WIN_LAT)
				lat_min = minutes_e4();
			else
				lon_min = minutes_e4();
		end
		phase = phase + 1'b1;
		if (int'(phase) >= deg_len + 7)
			win = WIN_NONE;
	endtask

	// Advance the parser by one character; a closing CR of an RMC sentence queues a fix
	task automatic parse_char(input logic [BYTE_W-1:0] c);
		fix_t             f;
		longint           lat_v;
		longint           lon_v;
		logic [POS_W-1:0] pos;
		if (c == CH_DOLLAR) begin
			clear_sentence();
			in_sent = 1'b1;
			char_pos = POS_W'(1);
		end else if (c == CH_CR) begin
			if (in_sent) begin
				in_sent = 1'b0;
				win = WIN_NONE;
				if (rmc) begin
					lat_v = to_e7(longint'(lat_deg), longint'(lat_min));
					lon_v = -to_e7(longint'(lon_deg), longint'(lon_min));
					if (lat_v > 10000000)
						sticky_valid = 1'b1;
					f.lat = lat_v[LAT_W-1:0];
					f.lon = lon_v[LON_W-1:0];
					f.valid = sticky_valid;
					expected_fixes.push_back(f);
					fixes_predicted++;
				end
			end
		end else if (in_sent && char_pos < MAX_SENTENCE) begin
			pos = char_pos;
			char_pos = char_pos + 1'b1;
			if (pos == 3 && c == CH_R)
				rmc = 1'b1;
			if (win != WIN_NONE)
				feed_window(c);
			if (c == CH_COMMA && commas < 7) begin
				commas = commas + 1'b1;
				// fifth comma drops any latitude window still open
				if (commas == 3)
					open_window(WIN_LAT);
				else if (commas == 5)
					open_window(WIN_LON);
			end
		end
	endtask

	// Compare first, then predict: a fix can never leave in the cycle of its CR
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_sentence();
			sticky_valid = 1'b0;
			expected_fixes.delete();
			fail_count = 0;
			fixes_due = 0;
			fixes_predicted = 0;
		end else begin
			if (fix.valid && fix.ready) begin
				if (expected_fixes.size() == 0) begin
					$display("%0t: position with none expected: expected none, actual lat %0d lon %0d valid %0b",
						$time, fix.latitude_e7, fix.longitude_e7, fix.position_valid);
					fail_count++;
				end else begin
					want = expected_fixes.pop_front();
					if (fix.latitude_e7 !== want.lat) begin
						$display("%0t: latitude_e7 expected %0d actual %0d",
							$time, want.lat, fix.latitude_e7);
						fail_count++;
					end
					if (fix.longitude_e7 !== want.lon) begin
						$display("%0t: longitude_e7 expected %0d actual %0d",
							$time, $signed(want.lon), fix.longitude_e7);
						fail_count++;
					end
					if (fix.position_valid !== want.valid) begin
						$display("%0t: position_valid expected %0b actual %0b",
							$time, want.valid, fix.position_valid);
						fail_count++;
					end
				end
			end
			if (rx.valid && rx.ready)
				parse_char(rx.rx_byte);
			fixes_due = expected_fixes.size();
		end
	end

endmodule

@@ dv/tb_nmea_position_sentence_parser.sv @@
`timescale 1ns / 100ps

module tb_nmea_position_sentence_parser;
	import npsp_pkg::*;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   fixes_due;
	int   fixes_predicted;

	// Stimulus bookkeeping
	int               src_idle_pct;
	int               sink_stall_pct;
	int               chars_sent;
	int               sentences_sent;
	logic [BYTE_W-1:0] line_buf[$];

	npsp_rx_if  rx_ch();
	npsp_fix_if fix_ch();

	nmea_position_sentence_parser u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (rx_ch),
		.fix   (fix_ch)
	);

	npsp_fix_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.rx             (rx_ch),
		.fix            (fix_ch),
		.fail_count     (fail_count),
		.fixes_due      (fixes_due),
		.fixes_predicted(fixes_predicted)
	);

	// 12 ns clock
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Random backpressure on the position channel
	always @(negedge clk) begin
		fix_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	// One character request, with random idle cycles ahead of it
	task automatic send_char(input logic [BYTE_W-1:0] c);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			rx_ch.valid <= 1'b0;
			@(negedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= c;
		@(posedge clk);
		while (!rx_ch.ready)
			@(posedge clk);
		chars_sent++;
		@(negedge clk);
	endtask

	task automatic send_line();
		foreach (line_buf[i])
			send_char(line_buf[i]);
		sentences_sent++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			line_buf.push_back(s[i]);
	endtask

	task automatic push_digits(input int n);
		for (int i = 0; i < n; i++)
			line_buf.push_back(BYTE_W'(int'(CH_ZERO) + $urandom_range(0, 9)));
	endtask

	// Printable filler, never a dollar
	task automatic push_junk(input int n);
		logic [BYTE_W-1:0] c;
		for (int i = 0; i < n; i++) begin
			c = BYTE_W'($urandom_range(32, 126));
			if (c == CH_DOLLAR)
				c = CH_POINT;
			line_buf.push_back(c);
		end
	endtask

	// Coordinate field: mostly ddmm.mmmm style, plus odd shapes
	task automatic push_coord(input int deg_digits);
		case ($urandom_range(0, 11))
			0: push_text(deg_digits == 2 ? "9999.9999" : "99999.9999");
			1: push_text(deg_digits == 2 ? "0000.0000" : "00000.0000");
			2: push_digits($urandom_range(0, 3));
			3: push_junk($urandom_range(1, 9));
			4: begin
				// oversized integer minutes saturate
				push_digits(deg_digits);
				push_digits($urandom_range(3, 7));
			end
			5: begin
				// second point ends the number
				push_digits(deg_digits);
				push_digits(2);
				push_text(".");
				push_digits(2);
				push_text(".");
				push_digits(2);
			end
			6: begin
				// sign or space in the middle
				push_digits($urandom_range(1, deg_digits));
				push_text($urandom_range(0, 1) ? "-" : " ");
				push_digits(2);
				push_text(".");
				push_digits(4);
			end
			default: begin
				push_digits(deg_digits);
				push_digits(2);
				push_text(".");
				push_digits($urandom_range(0, 6));
			end
		endcase
	endtask

	task automatic push_rmc_body();
		push_text(",");
		push_digits($urandom_range(0, 6));
		if ($urandom_range(0, 1))
			push_text(".00");
		push_text(",");
		push_text($urandom_range(0, 1) ? "A" : "V");
		push_text(",");
		push_coord(2);
		push_text($urandom_range(0, 1) ? ",N," : ",S,");
		push_coord(3);
		push_text($urandom_range(0, 1) ? ",W" : ",E");
		if ($urandom_range(0, 1))
			push_junk($urandom_range(0, 16));
	endtask

	// Build one sentence of random kind into line_buf
	task automatic make_sentence();
		int kind;
		int n;
		kind = $urandom_range(0, 99);
		line_buf.delete();
		if (kind < 70 || (kind >= 82 && kind < 90)) begin
			push_text($urandom_range(0, 3) == 0 ? "$GNRMC" : "$GPRMC");
			push_rmc_body();
		end else if (kind < 82) begin
			push_text($urandom_range(0, 1) ? "$GPGGA" : "$GPGSV");
			push_rmc_body();
		end else if (kind < 95) begin
			// fields never reached read as zero
			push_text($urandom_range(0, 1) ? "$GPR" : "$GPRMC,,");
		end else begin
			// abandoned start, restarted by a second dollar
			push_text("$GP");
			push_junk($urandom_range(0, 12));
			push_text("$GPRMC");
			push_rmc_body();
		end
		// corrupt a few characters with arbitrary bytes
		if (kind >= 55 && kind < 70) begin
			n = $urandom_range(1, 3);
			for (int i = 0; i < n; i++)
				line_buf[$urandom_range(1, line_buf.size() - 1)] =
					BYTE_W'($urandom_range(0, 255));
		end
		// run past the sentence bound
		if (kind >= 82 && kind < 86)
			push_junk($urandom_range(130, 170) - line_buf.size());
		// cut short, no carriage return
		if (kind >= 86 && kind < 90) begin
			line_buf = line_buf[0:$urandom_range(0, line_buf.size() - 1)];
		end else if ($urandom_range(0, 24) != 0) begin
			line_buf.push_back(CH_CR);
			if ($urandom_range(0, 1))
				line_buf.push_back(8'h0A);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = '0;
		src_idle_pct = 21;
		sink_stall_pct = 69;
		chars_sent = 0;
		sentences_sent = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: stray CR, then all-nines fields for the largest position
		send_char(CH_CR);
		line_buf.delete();
		push_text("$GPR,,,9999.9999,,99999.9999");
		line_buf.push_back(CH_CR);
		send_line();

		// Random sentences with noise between them
		while (chars_sent < 1100) begin
			if (chars_sent < 370) begin
				src_idle_pct = 21;
				sink_stall_pct = 69;
			end else if (chars_sent < 740) begin
				src_idle_pct = 69;
				sink_stall_pct = 21;
			end else begin
				src_idle_pct = 0;
				sink_stall_pct = 0;
			end
			if ($urandom_range(0, 11) == 0)
				send_char(CH_CR);
			if ($urandom_range(0, 11) == 0)
				repeat ($urandom_range(1, 4)) send_char(BYTE_W'($urandom_range(0, 255)));
			make_sentence();
			send_line();
		end
		rx_ch.valid <= 1'b0;

		// Drain and let the pipeline settle
		while (fixes_due != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);

		$display("Sent %0d sentences, %0d characters in all, %0d positions checked.",
			sentences_sent, chars_sent, fixes_predicted);
		$display("Idle mixes: light source / heavy sink, heavy source / light sink, none.");
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#4800000;
		$display("FAILURE");
		$finish;
	end

endmodule
